// ===== hw/rtl/pcl_pkg.sv =====
`default_nettype none

package pcl_pkg;

	localparam int FIELD_BITS = 32;
	localparam int POS_BITS = 5;
	localparam int COUNT_BITS = 5;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_DUMP_FWD = 2'd2,
		OP_DUMP_REV = 2'd3
	} op_t;

	localparam logic [1:0] PL_FRONT = 2'd0;
	localparam logic [1:0] PL_BACK  = 2'd1;
	localparam logic [1:0] PL_AT    = 2'd2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_HOLD = 2'd1,
		SRC_READ = 2'd2
	} src_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_INS,
		S_DEL,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]                   operation;
		logic [1:0]                   place;
		logic [POS_BITS-1:0]          position;
		logic signed [FIELD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                      status;
		logic signed [FIELD_BITS-1:0] item_value;
		logic [COUNT_BITS-1:0]        entry_count;
		logic                         last;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    init;
		logic    step;
		logic    shift;
		logic    put_val;
		logic    count_dec;
		logic    emit;
		src_t    emit_src;
		status_t emit_status;
		logic    emit_last;
	} cmd_t;

	typedef struct packed {
		status_t chk;
		op_t     op;
		logic    rem_zero;
		logic    rd_vld;
		logic    out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcl_ctrl.sv =====
`default_nettype none

module pcl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire pcl_pkg::sts_t  sts,
	output pcl_pkg::cmd_t       cmd
);

	pcl_pkg::state_t state_q;
	pcl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		cmd.emit_src = pcl_pkg::SRC_ZERO;
		cmd.emit_status = pcl_pkg::ST_OK;
		unique case (state_q)
			pcl_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
				if (req_valid) begin
					state_d = pcl_pkg::S_DECIDE;
				end
			end
			pcl_pkg::S_DECIDE: begin
				if (sts.chk != pcl_pkg::ST_OK) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_status = sts.chk;
						cmd.emit_last = 1'b1;
						state_d = pcl_pkg::S_IDLE;
					end
				end else begin
					cmd.init = 1'b1;
					unique case (sts.op)
						pcl_pkg::OP_INSERT: state_d = pcl_pkg::S_INS;
						pcl_pkg::OP_DELETE: state_d = pcl_pkg::S_DEL;
						pcl_pkg::OP_DUMP_FWD,
						pcl_pkg::OP_DUMP_REV: state_d = pcl_pkg::S_DUMP_RD;
					endcase
				end
			end
			pcl_pkg::S_INS: begin
				cmd.shift = 1'b1;
				if (!sts.rem_zero) begin
					cmd.step = 1'b1;
				end else if (!sts.rd_vld) begin
					cmd.put_val = 1'b1;
					state_d = pcl_pkg::S_FINISH;
				end
			end
			pcl_pkg::S_DEL: begin
				cmd.shift = 1'b1;
				if (!sts.rem_zero) begin
					cmd.step = 1'b1;
				end else if (!sts.rd_vld) begin
					cmd.count_dec = 1'b1;
					state_d = pcl_pkg::S_FINISH;
				end
			end
			pcl_pkg::S_DUMP_RD: begin
				cmd.step = 1'b1;
				state_d = pcl_pkg::S_DUMP_OUT;
			end
			pcl_pkg::S_DUMP_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_src = pcl_pkg::SRC_READ;
					cmd.emit_last = sts.rem_zero;
					if (!sts.rem_zero) begin
						cmd.step = 1'b1;
					end else begin
						state_d = pcl_pkg::S_IDLE;
					end
				end
			end
			pcl_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_src = (sts.op == pcl_pkg::OP_DELETE) ? pcl_pkg::SRC_HOLD
						: pcl_pkg::SRC_ZERO;
					state_d = pcl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pcl_pkg::S_IDLE;
			end
		endcase
	end

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while output register busy");

	a_put_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_val |-> (sts.rem_zero && !sts.rd_vld))
		else $error("value written before shift drained");

	a_accept_leads_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == pcl_pkg::S_DECIDE))
		else $error("accepted item not decided");

endmodule

`default_nettype wire

// ===== hw/rtl/pcl_dpath.sv =====
`default_nettype none

module pcl_dpath #(
	parameter int CAPACITY  = 16,
	parameter int DATA_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pcl_pkg::req_t req,
	input  wire pcl_pkg::cmd_t cmd,
	output pcl_pkg::sts_t      sts,
	output logic               rsp_valid,
	output pcl_pkg::rsp_t      rsp,
	input  wire logic          rsp_ready
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int WW = ((CW > pcl_pkg::POS_BITS) ? CW : pcl_pkg::POS_BITS) + 1;
	localparam int FB = pcl_pkg::FIELD_BITS;

	logic [DATA_BITS-1:0] mem [CAPACITY];

	pcl_pkg::op_t         op_q;
	logic [1:0]           place_q;
	logic [pcl_pkg::POS_BITS-1:0] pos_q;
	logic [DATA_BITS-1:0] val_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        rem_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic [DATA_BITS-1:0] rd_data_s1;
	logic                 rsp_valid_q;
	pcl_pkg::rsp_t        rsp_q;

	pcl_pkg::status_t     chk;
	logic [WW-1:0]        n_w;
	logic [WW-1:0]        pos_w;
	logic [WW-1:0]        cnt_w;
	logic [WW-1:0]        idx_w;
	logic [CW-1:0]        chk_idx;
	logic                 out_free;
	logic                 ptr_up;
	logic                 shift_wr;
	logic                 grab_rm;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [DATA_BITS-1:0] wr_data;
	logic [DATA_BITS-1:0] sel_data;
	logic [DATA_BITS+FB-1:0] in_wide;
	logic [DATA_BITS+FB-1:0] out_wide;

	assign n_w = WW'(count_q);
	assign pos_w = WW'(pos_q);
	assign cnt_w = WW'(count_q);

	always_comb begin
		chk = pcl_pkg::ST_OK;
		idx_w = '0;
		unique case (op_q)
			pcl_pkg::OP_INSERT: begin
				if (count_q == CW'(CAPACITY)) begin
					chk = pcl_pkg::ST_FULL;
				end else if (place_q == pcl_pkg::PL_FRONT) begin
					idx_w = '0;
				end else if (place_q == pcl_pkg::PL_BACK) begin
					idx_w = n_w;
				end else if (place_q == pcl_pkg::PL_AT && pos_w != '0
						&& pos_w <= n_w + WW'(1)) begin
					idx_w = pos_w - WW'(1);
				end else begin
					chk = pcl_pkg::ST_BADPOS;
				end
			end
			pcl_pkg::OP_DELETE: begin
				if (count_q == '0) begin
					chk = pcl_pkg::ST_EMPTY;
				end else if (place_q == pcl_pkg::PL_FRONT) begin
					idx_w = '0;
				end else if (place_q == pcl_pkg::PL_BACK) begin
					idx_w = n_w - WW'(1);
				end else if (place_q == pcl_pkg::PL_AT && pos_w != '0
						&& pos_w <= n_w) begin
					idx_w = pos_w - WW'(1);
				end else begin
					chk = pcl_pkg::ST_BADPOS;
				end
			end
			pcl_pkg::OP_DUMP_FWD,
			pcl_pkg::OP_DUMP_REV: begin
				if (count_q == '0) begin
					chk = pcl_pkg::ST_EMPTY;
				end
			end
		endcase
	end

	assign chk_idx = idx_w[CW-1:0];
	assign out_free = !rsp_valid_q || rsp_ready;
	assign ptr_up = (op_q == pcl_pkg::OP_DELETE) || (op_q == pcl_pkg::OP_DUMP_FWD);

	assign sts.chk = chk;
	assign sts.op = op_q;
	assign sts.rem_zero = (rem_q == '0);
	assign sts.rd_vld = rd_vld_s1;
	assign sts.out_free = out_free;

	// latch the item
	assign in_wide = {{DATA_BITS{1'b0}}, req.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= pcl_pkg::OP_INSERT;
		end else if (cmd.load) begin
			op_q <= pcl_pkg::op_t'(req.operation);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			place_q <= req.place;
			pos_q <= req.position;
			val_q <= in_wide[DATA_BITS-1:0];
		end else if (grab_rm) begin
			val_q <= rd_data_s1;
		end
	end

	// walk pointer and remaining reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ptr_q <= '0;
			rem_q <= '0;
		end else if (cmd.init) begin
			idx_q <= chk_idx;
			unique case (op_q)
				pcl_pkg::OP_INSERT: begin
					ptr_q <= count_q - CW'(1);
					rem_q <= count_q - chk_idx;
				end
				pcl_pkg::OP_DELETE: begin
					ptr_q <= chk_idx;
					rem_q <= count_q - chk_idx;
				end
				pcl_pkg::OP_DUMP_FWD: begin
					ptr_q <= '0;
					rem_q <= count_q;
				end
				pcl_pkg::OP_DUMP_REV: begin
					ptr_q <= count_q - CW'(1);
					rem_q <= count_q;
				end
			endcase
		end else if (cmd.step) begin
			ptr_q <= ptr_up ? ptr_q + CW'(1) : ptr_q - CW'(1);
			rem_q <= rem_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.step;
			if (cmd.put_val) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// entry memory: one write and one registered read per cycle
	assign grab_rm = cmd.shift && rd_vld_s1 && (op_q == pcl_pkg::OP_DELETE)
		&& (rd_addr_s1 == idx_q[AW-1:0]);
	assign shift_wr = cmd.shift && rd_vld_s1
		&& ((op_q == pcl_pkg::OP_INSERT) || (rd_addr_s1 != idx_q[AW-1:0]));
	assign wr_en = cmd.put_val || shift_wr;
	assign wr_data = cmd.put_val ? val_q : rd_data_s1;

	always_comb begin
		if (cmd.put_val) begin
			wr_addr = idx_q[AW-1:0];
		end else if (op_q == pcl_pkg::OP_INSERT) begin
			wr_addr = rd_addr_s1 + AW'(1);
		end else begin
			wr_addr = rd_addr_s1 - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_addr_s1 <= ptr_q[AW-1:0];
			rd_data_s1 <= mem[ptr_q[AW-1:0]];
		end
	end

	// result register
	always_comb begin
		unique case (cmd.emit_src)
			pcl_pkg::SRC_HOLD: sel_data = val_q;
			pcl_pkg::SRC_READ: sel_data = rd_data_s1;
			default:           sel_data = '0;
		endcase
	end

	assign out_wide = {{FB{sel_data[DATA_BITS-1]}}, sel_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status <= cmd.emit_status;
			rsp_q.item_value <= signed'(out_wide[FB-1:0]);
			rsp_q.entry_count <= cnt_w[pcl_pkg::COUNT_BITS-1:0];
			rsp_q.last <= cmd.emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_put_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_val |-> (count_q < CW'(CAPACITY)))
		else $error("insert into full list");

	a_no_drop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_dec |-> (count_q != '0))
		else $error("delete from empty list");

	a_count_steps_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.put_val && !cmd.count_dec) |=> $stable(count_q))
		else $error("entry count changed without command");

endmodule

`default_nettype wire

// ===== hw/rtl/positional_circular_list.sv =====
`default_nettype none

// Ordered list of up to CAPACITY values of DATA_BITS each, held in one
// single-port-write, registered-read memory in list order. A request
// inserts at the front, back or a 1-based position, deletes at the front,
// back or a position, or dumps the list forward or reversed; every request
// gives one response (status, value, entry count, last), a dump one per
// entry with last on the final one. Failed requests leave the list
// unchanged. The memory port sets the pace: an insert or delete moves each
// entry behind its index, and each moved entry costs one read and one write
// through the port; a dump reads each entry once through it. A new request
// is taken once the previous one has handed its last response to the output
// register.
module positional_circular_list #(
	parameter int CAPACITY  = 16,
	parameter int DATA_BITS = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire pcl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output pcl_pkg::rsp_t      rsp
);

	pcl_pkg::cmd_t cmd;
	pcl_pkg::sts_t sts;

	pcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcl_dpath #(
		.CAPACITY  (CAPACITY),
		.DATA_BITS (DATA_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

endmodule

`default_nettype wire

// ===== tb/tb_positional_circular_list.sv =====
`timescale 1ns / 100ps

module tb_positional_circular_list;

	localparam int LIST_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int CNT_W       = pcl_pkg::COUNT_BITS;
	localparam int POS_W       = pcl_pkg::POS_BITS;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	pcl_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	pcl_pkg::rsp_t  rsp;

	logic signed [pcl_pkg::FIELD_BITS-1:0] shadow_list[$];
	pcl_pkg::rsp_t                         expected_rsp[$];
	int                                    mismatches  = 0;
	int                                    idle_pct    = 0;
	int                                    fill_bias   = 50;
	int                                    stall_left  = 0;
	int                                    cycle_count = 0;

	positional_circular_list #(
		.CAPACITY (LIST_DEPTH),
		.DATA_BITS(pcl_pkg::FIELD_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// hold ready low in short random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (arst_n && $urandom_range(0, 99) < idle_pct) begin
			rsp_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pcl_pkg::rsp_t exp_r;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: status %0d value %0d count %0d last %0b",
						rsp.status, rsp.item_value, rsp.entry_count, rsp.last);
			end else begin
				exp_r = expected_rsp.pop_front();
				if (rsp.status !== exp_r.status || rsp.item_value !== exp_r.item_value ||
						rsp.entry_count !== exp_r.entry_count || rsp.last !== exp_r.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected status %0d value %0d count %0d last %0b",
							exp_r.status, exp_r.item_value, exp_r.entry_count, exp_r.last);
						$display("          got status %0d value %0d count %0d last %0b",
							rsp.status, rsp.item_value, rsp.entry_count, rsp.last);
					end
				end
			end
		end
	end

	function automatic void predict_result(input pcl_pkg::req_t item);
		int            n;
		int            idx;
		pcl_pkg::rsp_t e;
		n      = shadow_list.size();
		idx    = -1;
		e      = '0;
		e.last = 1'b1;
		case (pcl_pkg::op_t'(item.operation))
			pcl_pkg::OP_INSERT: begin
				if (n >= LIST_DEPTH) begin
					e.status = pcl_pkg::ST_FULL;
				end else begin
					if (item.place == pcl_pkg::PL_FRONT)
						idx = 0;
					else if (item.place == pcl_pkg::PL_BACK)
						idx = n;
					else if (item.place == pcl_pkg::PL_AT && item.position >= 1
							&& item.position <= n + 1)
						idx = item.position - 1;
					if (idx < 0) begin
						e.status = pcl_pkg::ST_BADPOS;
					end else begin
						shadow_list.insert(idx, item.value);
						e.status = pcl_pkg::ST_OK;
					end
				end
				e.entry_count = CNT_W'(shadow_list.size());
				expected_rsp.push_back(e);
			end
			pcl_pkg::OP_DELETE: begin
				if (n == 0) begin
					e.status = pcl_pkg::ST_EMPTY;
				end else begin
					if (item.place == pcl_pkg::PL_FRONT)
						idx = 0;
					else if (item.place == pcl_pkg::PL_BACK)
						idx = n - 1;
					else if (item.place == pcl_pkg::PL_AT && item.position >= 1
							&& item.position <= n)
						idx = item.position - 1;
					if (idx < 0) begin
						e.status = pcl_pkg::ST_BADPOS;
					end else begin
						e.item_value = shadow_list[idx];
						shadow_list.delete(idx);
						e.status = pcl_pkg::ST_OK;
					end
				end
				e.entry_count = CNT_W'(shadow_list.size());
				expected_rsp.push_back(e);
			end
			default: begin
				if (n == 0) begin
					e.status = pcl_pkg::ST_EMPTY;
					expected_rsp.push_back(e);
				end else begin
					for (int i = 0; i < n; i++) begin
						e.status      = pcl_pkg::ST_OK;
						e.item_value  = (item.operation == pcl_pkg::OP_DUMP_FWD) ?
							shadow_list[i] : shadow_list[n - 1 - i];
						e.entry_count = CNT_W'(n);
						e.last        = (i == n - 1);
						expected_rsp.push_back(e);
					end
				end
			end
		endcase
	endfunction

	function automatic pcl_pkg::req_t make_item(input logic [1:0] op, input logic [1:0] place,
			input int pos, input logic [pcl_pkg::FIELD_BITS-1:0] value);
		pcl_pkg::req_t r;
		r.operation = op;
		r.place     = place;
		r.position  = pos[POS_W-1:0];
		r.value     = value;
		return r;
	endfunction

	task automatic send_item(input pcl_pkg::req_t item);
		int gap;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_result(item);
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list;
		send_item(make_item(pcl_pkg::OP_DUMP_FWD, pcl_pkg::PL_FRONT, 0, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, pcl_pkg::PL_FRONT, 0, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, pcl_pkg::PL_BACK, 1, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, 2'd3, 31, 32'hFFFF_FFFF));
		drain();
	endtask

	task automatic test_single_entry;
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_AT, 1, 32'h1234_5678));
		send_item(make_item(pcl_pkg::OP_DELETE, pcl_pkg::PL_AT, 1, 32'h0));
		send_item(make_item(pcl_pkg::OP_DUMP_REV, pcl_pkg::PL_BACK, 3, 32'h0));
		drain();
	endtask

	task automatic test_positions;
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_FRONT, 0, 32'h7FFF_FFFF));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_BACK, 0, 32'h8000_0000));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_AT, 1, 32'hFFFF_FFFF));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_AT, 4, 32'h0));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_AT, 0, 32'h5555_5555));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_AT, 6, 32'hAAAA_AAAA));
		send_item(make_item(pcl_pkg::OP_INSERT, 2'd3, 1, 32'h1));
		send_item(make_item(pcl_pkg::OP_DUMP_FWD, 2'd3, 31, 32'hFFFF_FFFF));
		drain();
	endtask

	task automatic test_full_list;
		while (shadow_list.size() < LIST_DEPTH)
			send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_BACK, 0, $urandom()));
		send_item(make_item(pcl_pkg::OP_INSERT, pcl_pkg::PL_FRONT, 0, 32'h1));
		send_item(make_item(pcl_pkg::OP_INSERT, 2'd3, 0, 32'h1));
		send_item(make_item(pcl_pkg::OP_DUMP_REV, pcl_pkg::PL_FRONT, 0, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, pcl_pkg::PL_AT, 16, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, pcl_pkg::PL_AT, 16, 32'h0));
		send_item(make_item(pcl_pkg::OP_DELETE, 2'd3, 2, 32'h0));
		drain();
	endtask

	function automatic pcl_pkg::req_t random_item;
		pcl_pkg::req_t r;
		int            n;
		int            roll;
		n    = shadow_list.size();
		roll = $urandom_range(0, 99);
		if (roll < 8)
			r.operation = pcl_pkg::OP_DUMP_FWD;
		else if (roll < 16)
			r.operation = pcl_pkg::OP_DUMP_REV;
		else if ($urandom_range(0, 99) < fill_bias)
			r.operation = pcl_pkg::OP_INSERT;
		else
			r.operation = pcl_pkg::OP_DELETE;
		roll = $urandom_range(0, 19);
		if (roll < 6)
			r.place = pcl_pkg::PL_FRONT;
		else if (roll < 12)
			r.place = pcl_pkg::PL_BACK;
		else if (roll < 19)
			r.place = pcl_pkg::PL_AT;
		else
			r.place = 2'd3;
		if ($urandom_range(0, 9) == 0)
			r.position = POS_W'($urandom_range(0, 31));
		else if (r.operation == pcl_pkg::OP_INSERT)
			r.position = POS_W'($urandom_range(1, n + 1));
		else
			r.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
		r.value = $urandom();
		return r;
	endfunction

	task automatic test_random_mix(input int count);
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       fill_bias = 25;
					1:       fill_bias = 50;
					default: fill_bias = 85;
				endcase
				idle_pct = (k >= count - 80) ? 0 : 10 * $urandom_range(0, 3);
			end
			send_item(random_item());
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 20;
		test_empty_list();
		test_single_entry();
		test_positions();
		test_full_list();
		test_random_mix(400);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
